// ===== design/ssa_pkg.sv =====
// Shared types and constants for the sample statistics archive.
`default_nettype none

package ssa_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 256;
	localparam int unsigned SAMPLE_BITS       = 16;

	localparam int unsigned VAL_W  = 16;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned AGE_W  = 8;
	localparam int unsigned ACT_W  = 2;
	localparam int unsigned ENTRY_W = 3 * VAL_W;

	localparam logic [VAL_W-1:0] NO_DATA   = 16'hFFFF;
	localparam logic [VAL_W-1:0] MIN_RESET = 16'hFFFE;
	localparam logic [VAL_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam logic [VAL_W-1:0] SAMPLE_MASK =
		(SAMPLE_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((32'd1 << SAMPLE_BITS) - 32'd1);

	typedef enum logic [ACT_W-1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_CRC    = 2'd1,
		ACT_CLOSE  = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	// controller to datapath
	typedef struct packed {
		logic upd_sample;
		logic upd_error;
		logic clear_period;
		logic div_start_mean;
		logic div_start_rate;
		logic take_mean;
		logic commit;
		logic read_mem;
		logic load_out;
	} ssa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_nz;
		logic div_done;
		logic out_busy;
	} ssa_status_t;

endpackage

`default_nettype wire

// ===== design/sample_stats_archive_core.sv =====
// Sensor sample statistics block with a circular period history.
//
// Input stream: s_tuser carries the event kind (sample, CRC error, close
// period, read history); s_tdata carries the sample value and the history
// age. Output stream: one transfer per history read, carrying the entry's
// mean, peak and floor with the smoothed error rate, and a has-data flag.
//
// Sample and CRC-error events are applied at acceptance and leave the input
// ready. A close with samples runs the shared one-bit-per-cycle divider
// twice (mean, then error ratio) and commits the entry when the second
// division is done; a close without samples clears the period at acceptance.
// A read fetches the history entry at acceptance, then loads the output
// register once it is free and frees the input with that load. s_tready is
// low while an item is at work.
//
// Reset clears the accumulators, the error rate and the history pointer;
// a fill count marks history entries not yet written, which read as no
// data, so no clearing sweep follows reset. When the receiver stalls, the
// result is held in the output register and a further read waits for it.
`default_nettype none

module sample_stats_archive_core #(
	parameter int unsigned HISTORY_DEPTH = ssa_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // sample[15:0], age_index[23:16]
	input  wire logic [1:0]  s_tuser,  // action[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // mean_value, peak_value, floor_value, error_rate
	output logic             m_tuser   // has_data
);

	ssa_pkg::ssa_cmd_t    cmd;
	ssa_pkg::ssa_status_t status;

	ssa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.action   (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ssa_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (s_tdata[15:0]),
		.age_index    (s_tdata[23:16]),
		.status       (status),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_data     (m_tdata),
		.out_has_data (m_tuser)
	);

endmodule

`default_nettype wire

// ===== design/ssa_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
`default_nettype none

module ssa_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ssa_pkg::SUM_W-1:0] dividend,
	input  wire logic [ssa_pkg::VAL_W-1:0] divisor,
	output logic                           done,
	output logic [ssa_pkg::SUM_W-1:0]      quotient
);

	localparam int unsigned CNT_W = $clog2(ssa_pkg::SUM_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [ssa_pkg::VAL_W-1:0] rem_q;
	logic [ssa_pkg::VAL_W-1:0] dsr_q;
	logic [ssa_pkg::SUM_W-1:0] quo_q;

	logic [ssa_pkg::VAL_W:0]   trial;
	logic [ssa_pkg::VAL_W:0]   diff;
	logic                      qbit;

	always_comb begin
		trial = {rem_q, quo_q[ssa_pkg::SUM_W-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ssa_pkg::SUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift in next dividend bit, subtract the divisor if the trial fits
			rem_q <= qbit ? diff[ssa_pkg::VAL_W-1:0] : trial[ssa_pkg::VAL_W-1:0];
			quo_q <= {quo_q[ssa_pkg::SUM_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== design/ssa_ctrl.sv =====
// Controller state machine sequencing events, period close and history reads.
`default_nettype none

module ssa_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [ssa_pkg::ACT_W-1:0] action,
	output logic                           in_ready,
	input  wire ssa_pkg::ssa_status_t      status,
	output ssa_pkg::ssa_cmd_t              cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MEAN = 4'b0010,
		ST_RATE = 4'b0100,
		ST_READ = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (ssa_pkg::action_t'(action))
						ssa_pkg::ACT_SAMPLE: cmd.upd_sample = 1'b1;
						ssa_pkg::ACT_CRC:    cmd.upd_error  = 1'b1;
						ssa_pkg::ACT_CLOSE: begin
							if (status.count_nz) begin
								cmd.div_start_mean = 1'b1;
								state_d            = ST_MEAN;
							end else begin
								cmd.clear_period = 1'b1;
							end
						end
						ssa_pkg::ACT_READ: begin
							cmd.read_mem = 1'b1;
							state_d      = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_MEAN: begin
				if (status.div_done) begin
					cmd.take_mean      = 1'b1;
					cmd.div_start_rate = 1'b1;
					state_d            = ST_RATE;
				end
			end
			ST_RATE: begin
				if (status.div_done) begin
					cmd.commit       = 1'b1;
					cmd.clear_period = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			ST_READ: begin
				// hold until the output register is free
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/ssa_dp.sv =====
// Datapath: accumulators, divider, history memory and output register.
`default_nettype none

module ssa_dp #(
	parameter int unsigned HISTORY_DEPTH = ssa_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ssa_pkg::ssa_cmd_t         cmd,
	input  wire logic [ssa_pkg::VAL_W-1:0] sample,
	input  wire logic [ssa_pkg::AGE_W-1:0] age_index,
	output ssa_pkg::ssa_status_t           status,
	input  wire logic                      out_ready,
	output logic                           out_valid,
	output logic [4*ssa_pkg::VAL_W-1:0]    out_data,
	output logic                           out_has_data
);

	localparam int unsigned VW     = ssa_pkg::VAL_W;
	localparam int unsigned PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned CMP_W  = (FILL_W > ssa_pkg::AGE_W) ? FILL_W : ssa_pkg::AGE_W;
	localparam int unsigned SLOT_W = ((PTR_W > ssa_pkg::AGE_W) ? PTR_W : ssa_pkg::AGE_W) + 1;

	// accumulators
	logic [ssa_pkg::SUM_W-1:0] sum_q;
	logic [VW-1:0]             count_q;
	logic [VW-1:0]             err_q;
	logic [VW-1:0]             max_q;
	logic [VW-1:0]             min_q;
	logic [VW-1:0]             rate_q;
	logic [VW-1:0]             mean_q;
	logic [PTR_W-1:0]          newest_q;
	logic [FILL_W-1:0]         fill_q;

	logic [ssa_pkg::ENTRY_W-1:0] mem [HISTORY_DEPTH];
	logic [ssa_pkg::ENTRY_W-1:0] rd_q;
	logic                        hit_q;

	logic                        out_valid_q;
	logic [4*VW-1:0]             out_data_q;
	logic                        out_has_q;

	logic [VW-1:0]             masked;
	logic [VW-1:0]             sval;
	logic [ssa_pkg::SUM_W-1:0] div_dividend;
	logic                      div_start;
	logic                      div_done;
	logic [ssa_pkg::SUM_W-1:0] div_quo;
	logic [VW-1:0]             ratio;
	logic [VW:0]               rate_sum;
	logic [PTR_W-1:0]          wr_addr;
	logic [SLOT_W-1:0]         slot_sum;
	logic [SLOT_W-1:0]         slot;
	logic                      hit;

	always_comb begin
		masked = sample & ssa_pkg::SAMPLE_MASK;
		sval   = (masked > ssa_pkg::MIN_RESET) ? ssa_pkg::MIN_RESET : masked;
	end

	assign div_start    = cmd.div_start_mean || cmd.div_start_rate;
	assign div_dividend = cmd.div_start_mean ? sum_q
		: {{(ssa_pkg::SUM_W - VW - 8){1'b0}}, err_q, 8'h00};

	ssa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		ratio    = (div_quo[ssa_pkg::SUM_W-1:VW] != '0) ? {VW{1'b1}} : div_quo[VW-1:0];
		rate_sum = {1'b0, rate_q} + {1'b0, ratio};
		wr_addr  = (newest_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : newest_q - 1'b1;
		slot_sum = SLOT_W'(newest_q) + SLOT_W'(age_index);
		slot     = (slot_sum >= SLOT_W'(HISTORY_DEPTH)) ? slot_sum - SLOT_W'(HISTORY_DEPTH)
			: slot_sum;
		// entries are filled newest first, so ages below the fill count are written
		hit      = CMP_W'(age_index) < CMP_W'(fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			err_q    <= '0;
			max_q    <= '0;
			min_q    <= ssa_pkg::MIN_RESET;
			rate_q   <= '0;
			newest_q <= '0;
			fill_q   <= '0;
		end else begin
			if (cmd.upd_sample) begin
				if (sval > max_q) max_q <= sval;
				if (sval < min_q) min_q <= sval;
				if (count_q != ssa_pkg::COUNT_MAX) begin
					sum_q   <= sum_q + ssa_pkg::SUM_W'(sval);
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.upd_error && err_q != ssa_pkg::COUNT_MAX) begin
				err_q <= err_q + 1'b1;
			end
			if (cmd.commit) begin
				rate_q   <= rate_sum[VW:1];
				newest_q <= wr_addr;
				if (fill_q != FILL_W'(HISTORY_DEPTH)) fill_q <= fill_q + 1'b1;
			end
			if (cmd.clear_period) begin
				sum_q   <= '0;
				count_q <= '0;
				err_q   <= '0;
				max_q   <= '0;
				min_q   <= ssa_pkg::MIN_RESET;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_mean) mean_q <= div_quo[VW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) mem[wr_addr] <= {min_q, max_q, mean_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.read_mem) begin
			rd_q  <= mem[slot[PTR_W-1:0]];
			hit_q <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= hit_q ? {rate_q, rd_q}
				: {rate_q, ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, ssa_pkg::NO_DATA};
			out_has_q  <= hit_q;
		end
	end

	assign status.count_nz = (count_q != '0);
	assign status.div_done = div_done;
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_has_data = out_has_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the sample statistics archive core.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned DEPTH        = ssa_pkg::HISTORY_DEPTH_DEF;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned RANDOM_ITEMS = 760;
	localparam int unsigned CRC_BURST    = 260;
	localparam int unsigned ROWS         = 25;

	typedef struct packed {
		logic [15:0] mean;
		logic [15:0] peak;
		logic [15:0] low;
		logic [15:0] rate;
		logic        has_data;
	} read_result_t;

	typedef struct packed {
		logic [15:0] mean;
		logic [15:0] peak;
		logic [15:0] low;
	} period_entry_t;

	typedef struct {
		ssa_pkg::action_t act;
		logic [15:0]      sample;
		logic [7:0]       age;
		bit               typed;
		read_result_t     want;
	} stim_row_t;

	localparam read_result_t EMPTY_AT_RESET =
		'{ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, 16'd0, 1'b0};
	localparam read_result_t EMPTY_RATE_42  =
		'{ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, 16'd42, 1'b0};
	localparam read_result_t FIRST_RATE_42  = '{16'd43689, 16'd65534, 16'd0, 16'd42, 1'b1};
	localparam read_result_t SECOND_RATE_277 = '{16'd7, 16'd7, 16'd7, 16'd277, 1'b1};
	localparam read_result_t FIRST_RATE_277 = '{16'd43689, 16'd65534, 16'd0, 16'd277, 1'b1};

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // sample[15:0], age_index[23:16]
	logic [1:0]  s_tuser  = '0;  // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // mean[15:0], peak[31:16], floor[47:32], error_rate[63:48]
	logic        m_tuser;        // has_data

	// predictor state
	logic [31:0]   acc_sum;
	logic [15:0]   acc_count;
	logic [15:0]   crc_count;
	logic [15:0]   acc_peak;
	logic [15:0]   acc_floor;
	logic [15:0]   rate_q88;
	period_entry_t archive [DEPTH];
	int unsigned   head_slot;

	read_result_t pending_reads [$];
	stim_row_t    directed_rows [ROWS];
	int unsigned  mismatch_count  = 0;
	int unsigned  reads_delivered = 0;
	int unsigned  idle_cycles     = 0;
	bit           gaps_off        = 1'b0;

	sample_stats_archive_core #(.HISTORY_DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_accumulators();
		acc_sum   = '0;
		acc_count = '0;
		crc_count = '0;
		acc_peak  = '0;
		acc_floor = ssa_pkg::MIN_RESET;
	endfunction

	function automatic void predict_event(input ssa_pkg::action_t act, input logic [15:0] raw,
			input logic [7:0] age, output bit produced, output read_result_t res);
		logic [15:0]   s;
		logic [31:0]   ratio;
		period_entry_t e;
		produced = 1'b0;
		res      = '0;
		case (act)
			ssa_pkg::ACT_SAMPLE: begin
				s = raw & ssa_pkg::SAMPLE_MASK;
				if (s > ssa_pkg::MIN_RESET)
					s = ssa_pkg::MIN_RESET;
				if (s > acc_peak)
					acc_peak = s;
				if (s < acc_floor)
					acc_floor = s;
				// a full count freezes sum and count, not the extremes
				if (acc_count != ssa_pkg::COUNT_MAX) begin
					acc_sum   = acc_sum + 32'(s);
					acc_count = acc_count + 16'd1;
				end
			end
			ssa_pkg::ACT_CRC: begin
				if (crc_count != ssa_pkg::COUNT_MAX)
					crc_count = crc_count + 16'd1;
			end
			ssa_pkg::ACT_CLOSE: begin
				if (acc_count != 0) begin
					ratio = {8'd0, crc_count, 8'd0} / 32'(acc_count);
					if (ratio > 32'd65535)
						ratio = 32'd65535;
					head_slot = (head_slot + DEPTH - 1) % DEPTH;
					archive[head_slot] = '{16'(acc_sum / 32'(acc_count)), acc_peak, acc_floor};
					rate_q88 = 16'((32'(rate_q88) + ratio) >> 1);
				end
				clear_accumulators();
			end
			ssa_pkg::ACT_READ: begin
				produced = 1'b1;
				if (32'(age) < DEPTH) begin
					e   = archive[(head_slot + 32'(age)) % DEPTH];
					res = '{e.mean, e.peak, e.low, rate_q88, e.mean != ssa_pkg::NO_DATA};
				end else begin
					res = '{ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, rate_q88, 1'b0};
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		case (r)
			0, 1, 2: return 16'd0;
			3, 4, 5: return ssa_pkg::MIN_RESET;
			6, 7:    return ssa_pkg::NO_DATA;
			8, 9:    return 16'($urandom_range(65500, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_age();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range(0, 8));
		if (r < 70)
			return 8'($urandom_range(254, 255));
		return 8'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Offer one item and hold it until the transfer; predict at acceptance.
	task automatic send_item(input ssa_pkg::action_t act, input logic [15:0] smp,
			input logic [7:0] age, input bit typed, input read_result_t want);
		int unsigned  gap;
		bit           produced;
		read_result_t res;
		gap = gaps_off ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {age, smp};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		predict_event(act, smp, age, produced, res);
		if (produced)
			pending_reads.push_back(typed ? want : res);
	endtask

	always @(posedge clk) begin : check_results
		read_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			reads_delivered++;
			if (pending_reads.size() == 0) begin
				report_mismatch("result with no read pending", m_tdata[15:0], 0);
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata[15:0] !== want.mean)
					report_mismatch("mean_value", m_tdata[15:0], want.mean);
				if (m_tdata[31:16] !== want.peak)
					report_mismatch("peak_value", m_tdata[31:16], want.peak);
				if (m_tdata[47:32] !== want.low)
					report_mismatch("floor_value", m_tdata[47:32], want.low);
				if (m_tdata[63:48] !== want.rate)
					report_mismatch("error_rate", m_tdata[63:48], want.rate);
				if (m_tuser !== want.has_data)
					report_mismatch("has_data", m_tuser, want.has_data);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, one long hold-off once reads are flowing.
	initial begin
		int unsigned n;
		bit          long_done;
		long_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_done && reads_delivered >= 40) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_done = 1'b1;
			end
			n = pick_gap();
			if (n != 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		int unsigned n;
		int unsigned k;
		int unsigned r;
		int unsigned burst;
		int unsigned random_sent;

		clear_accumulators();
		rate_q88  = '0;
		head_slot = 0;
		foreach (archive[i])
			archive[i] = '{ssa_pkg::NO_DATA, ssa_pkg::NO_DATA, ssa_pkg::NO_DATA};

		directed_rows = '{
			'{ssa_pkg::ACT_READ,   16'd0,     8'd0,   1'b1, EMPTY_AT_RESET},
			'{ssa_pkg::ACT_READ,   16'hFFFF,  8'd255, 1'b1, EMPTY_AT_RESET},
			'{ssa_pkg::ACT_CLOSE,  16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd0,   1'b1, EMPTY_AT_RESET},
			'{ssa_pkg::ACT_SAMPLE, 16'd0,     8'hFF,  1'b0, '0},
			'{ssa_pkg::ACT_SAMPLE, 16'd65534, 8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_SAMPLE, 16'd65535, 8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_CRC,    16'hFFFF,  8'hFF,  1'b0, '0},
			'{ssa_pkg::ACT_CLOSE,  16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd0,   1'b1, FIRST_RATE_42},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd1,   1'b1, EMPTY_RATE_42},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd255, 1'b1, EMPTY_RATE_42},
			'{ssa_pkg::ACT_SAMPLE, 16'd7,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_CRC,    16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_CRC,    16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_CLOSE,  16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd0,   1'b1, SECOND_RATE_277},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd1,   1'b1, FIRST_RATE_277},
			'{ssa_pkg::ACT_SAMPLE, 16'hAAAA,  8'h55,  1'b0, '0},
			'{ssa_pkg::ACT_SAMPLE, 16'h5555,  8'hAA,  1'b0, '0},
			'{ssa_pkg::ACT_CLOSE,  16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_CRC,    16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_CLOSE,  16'd0,     8'd0,   1'b0, '0},
			'{ssa_pkg::ACT_READ,   16'd0,     8'd2,   1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].act, directed_rows[i].sample, directed_rows[i].age,
				directed_rows[i].typed, directed_rows[i].want);

		// Error ratio beyond 16 bits: one sample, many CRC errors.
		gaps_off = 1'b1;
		send_item(ssa_pkg::ACT_SAMPLE, 16'd1000, 8'd0, 1'b0, '0);
		repeat (CRC_BURST) send_item(ssa_pkg::ACT_CRC, 16'd0, 8'd0, 1'b0, '0);
		send_item(ssa_pkg::ACT_CLOSE, 16'd0, 8'd0, 1'b0, '0);
		send_item(ssa_pkg::ACT_READ, 16'd0, 8'd0, 1'b0, '0);
		send_item(ssa_pkg::ACT_READ, 16'd0, 8'd1, 1'b0, '0);
		gaps_off = 1'b0;

		// Mostly whole periods with random content, some noise and unclosed periods.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			gaps_off = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) < 8) begin
				send_item(ssa_pkg::action_t'($urandom_range(0, 3)), 16'($urandom),
					8'($urandom), 1'b0, '0);
				random_sent++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15)
					n = 0;
				else if (r < 55)
					n = 1;
				else if (r < 85)
					n = $urandom_range(2, 5);
				else
					n = $urandom_range(6, 30);
				for (k = 0; k < n; k++) begin
					send_item(ssa_pkg::ACT_SAMPLE, pick_sample(), 8'($urandom), 1'b0, '0);
					random_sent++;
					if ($urandom_range(0, 5) == 0) begin
						send_item(ssa_pkg::ACT_CRC, 16'($urandom), 8'($urandom), 1'b0, '0);
						random_sent++;
					end
				end
				if ($urandom_range(0, 9) == 0) begin
					burst = $urandom_range(1, 12);
					repeat (burst)
						send_item(ssa_pkg::ACT_CRC, 16'($urandom), 8'($urandom), 1'b0, '0);
					random_sent += burst;
				end
				if ($urandom_range(0, 9) != 0) begin
					send_item(ssa_pkg::ACT_CLOSE, 16'($urandom), 8'($urandom), 1'b0, '0);
					random_sent++;
				end
				n = $urandom_range(0, 2);
				for (k = 0; k < n; k++) begin
					send_item(ssa_pkg::ACT_READ, 16'($urandom), pick_age(), 1'b0, '0);
					random_sent++;
				end
			end
		end
		s_tvalid <= 1'b0;

		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
